FILE: rtl/tct_pkg.sv
package tct_pkg;

    // Operation codes carried by the opcode field of an input beat.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Fixed field widths.
    localparam int SIZE_W = 15;
    localparam int GRID_W = 10;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // The query token handed from one cell to the next.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
    } t_token;

endpackage

FILE: rtl/tct_cell.sv
module tct_cell #(
    parameter int COORD_BITS = 16,
    parameter int CNT_W      = 9,
    parameter int INDEX      = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [CNT_W-1:0]               i_count,
    input  logic                           i_wr,
    input  logic signed [COORD_BITS-1:0]   i_box_x,
    input  logic signed [COORD_BITS-1:0]   i_box_y,
    input  logic [tct_pkg::SIZE_W-1:0]     i_box_w,
    input  logic [tct_pkg::SIZE_W-1:0]     i_box_h,
    input  logic [tct_pkg::GRID_W-1:0]     i_row,
    input  logic [tct_pkg::GRID_W-1:0]     i_col,
    input  logic                           i_brk,
    input  tct_pkg::t_token                i_tok,
    output tct_pkg::t_token                o_tok
);

    // Sums need two bits beyond the wider of a coordinate and a size.
    localparam int BASE_W = (COORD_BITS > tct_pkg::SIZE_W) ? COORD_BITS : tct_pkg::SIZE_W;
    localparam int SUM_W  = BASE_W + 2;

    logic signed [COORD_BITS-1:0]   r_x;
    logic signed [COORD_BITS-1:0]   r_y;
    logic [tct_pkg::SIZE_W-1:0]     r_w;
    logic [tct_pkg::SIZE_W-1:0]     r_h;
    logic [tct_pkg::GRID_W-1:0]     r_row;
    logic [tct_pkg::GRID_W-1:0]     r_col;
    logic                           r_active;
    tct_pkg::t_token                r_tok;
    tct_pkg::t_token                n_tok;

    logic                           w_sel;
    logic                           w_live;
    logic                           w_touch;
    logic                           w_hit;
    logic signed [SUM_W-1:0]        w_qx, w_qy, w_qw, w_qh;
    logic signed [SUM_W-1:0]        w_tx, w_ty, w_tw, w_th;

    assign w_sel  = i_count == CNT_W'(INDEX);
    assign w_live = CNT_W'(INDEX) < i_count;

    assign w_qx = SUM_W'(i_box_x);
    assign w_qy = SUM_W'(i_box_y);
    assign w_qw = signed'(SUM_W'(i_box_w));
    assign w_qh = signed'(SUM_W'(i_box_h));
    assign w_tx = SUM_W'(r_x);
    assign w_ty = SUM_W'(r_y);
    assign w_tw = signed'(SUM_W'(r_w));
    assign w_th = signed'(SUM_W'(r_h));

    // Inclusive edges: boxes that only touch still count.
    assign w_touch = (w_qx + w_qw >= w_tx) && (w_tx + w_tw >= w_qx) &&
                     (w_qy + w_qh >= w_ty) && (w_ty + w_th >= w_qy);

    assign w_hit = i_tok.valid && !i_tok.found && w_live && r_active && w_touch;

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.row   = r_row;
            n_tok.col   = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && w_sel) begin
            r_x   <= i_box_x;
            r_y   <= i_box_y;
            r_w   <= i_box_w;
            r_h   <= i_box_h;
            r_row <= i_row;
            r_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && w_sel) begin
            r_active <= 1'b1;
        end else if (w_hit && i_brk) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.row   <= n_tok.row;
        r_tok.col   <= n_tok.col;
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/tile_collision_table.sv
// Tile collision table: a store of axis-aligned tile boxes with an overlap query.
// Input channel: i_in_valid / o_in_stall carry one operation beat (add tile,
// clear table or query box). Output channel: o_out_valid / i_out_stall return
// exactly one result beat for every input beat, in order.
// Each tile lives in a cell of a chain of MAX_TILES cells. A query launches a
// token into the first cell; the token moves one cell per clock and the first
// active, overlapping tile marks it (and is deactivated when breaking is allowed).
// Throughput is one operation at a time: the input stalls until the previous
// operation is finished. An add, a clear or an unused code passes from the execute
// state to the finish state. A query passes from the execute state to the scan
// state, which waits out the token's walk along the cell chain, then finishes.
// The result sits in an output register, so the next beat is taken as soon as the
// previous operation has been handed to that register, even while it is stalled.
// While i_out_stall is high the offered result holds steady; a finished result
// waits internally until the output register frees up.
// Reset (synchronous, active low) empties the table and drops any pending beat;
// cell contents are not cleared and are never read before being written again.
module tile_collision_table #(
    parameter int MAX_TILES  = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic signed [COORD_BITS-1:0] i_box_x,
    input  logic signed [COORD_BITS-1:0] i_box_y,
    input  logic [tct_pkg::SIZE_W-1:0]   i_box_w,
    input  logic [tct_pkg::SIZE_W-1:0]   i_box_h,
    input  logic [tct_pkg::GRID_W-1:0]   i_grid_row,
    input  logic [tct_pkg::GRID_W-1:0]   i_grid_col,
    input  logic                         i_can_break,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic                         o_broken,
    output logic [tct_pkg::GRID_W-1:0]   o_hit_row,
    output logic [tct_pkg::GRID_W-1:0]   o_hit_col,
    output logic                         o_status
);

    localparam int CNT_W = $clog2(MAX_TILES + 1);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;

    // Operation registers, captured when a beat is accepted.
    logic [1:0]                     r_op;
    logic signed [COORD_BITS-1:0]   r_box_x, r_box_y;
    logic [tct_pkg::SIZE_W-1:0]     r_box_w, r_box_h;
    logic [tct_pkg::GRID_W-1:0]     r_row, r_col;
    logic                           r_brk;

    // Pending result, waiting for the output register.
    logic                           r_res_hit, n_res_hit;
    logic                           r_res_broken, n_res_broken;
    logic [tct_pkg::GRID_W-1:0]     r_res_row, n_res_row;
    logic [tct_pkg::GRID_W-1:0]     r_res_col, n_res_col;
    logic                           r_res_status, n_res_status;

    logic                           r_out_valid;
    logic                           r_hit, r_broken, r_status;
    logic [tct_pkg::GRID_W-1:0]     r_hit_row, r_hit_col;

    logic                           w_accept;
    logic                           w_full;
    logic                           w_wr;
    logic                           w_slot_free;
    tct_pkg::t_token                w_tok [MAX_TILES+1];

    assign o_in_stall  = r_state != S_IDLE;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = r_count == CNT_W'(MAX_TILES);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_wr        = (r_state == S_EXEC) && (r_op == tct_pkg::OP_ADD) && !w_full;

    // The token enters the first cell in the cycle a query executes.
    always_comb begin
        w_tok[0].valid = (r_state == S_EXEC) && (r_op == tct_pkg::OP_QUERY);
        w_tok[0].found = 1'b0;
        w_tok[0].row   = '0;
        w_tok[0].col   = '0;
    end

    for (genvar g = 0; g < MAX_TILES; g++) begin : g_cell
        tct_cell #(
            .COORD_BITS (COORD_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_wr    (w_wr),
            .i_box_x (r_box_x),
            .i_box_y (r_box_y),
            .i_box_w (r_box_w),
            .i_box_h (r_box_h),
            .i_row   (r_row),
            .i_col   (r_col),
            .i_brk   (r_brk),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Sequencer: executes an accepted operation, waits for a query token to
    // leave the last cell, then hands the result to the output register.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_res_hit    = r_res_hit;
        n_res_broken = r_res_broken;
        n_res_row    = r_res_row;
        n_res_col    = r_res_col;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_hit    = 1'b0;
                n_res_broken = 1'b0;
                n_res_row    = '0;
                n_res_col    = '0;
                n_res_status = tct_pkg::STATUS_OK;
                n_state      = S_FIN;
                case (r_op)
                    tct_pkg::OP_ADD: begin
                        if (w_full) begin
                            n_res_status = tct_pkg::STATUS_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    tct_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    tct_pkg::OP_QUERY: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        // Unused code: nothing changes, an all-zero result goes out.
                    end
                endcase
            end
            S_SCAN: begin
                if (w_tok[MAX_TILES].valid) begin
                    n_res_hit    = w_tok[MAX_TILES].found;
                    n_res_broken = w_tok[MAX_TILES].found && r_brk;
                    n_res_row    = w_tok[MAX_TILES].row;
                    n_res_col    = w_tok[MAX_TILES].col;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_box_x <= i_box_x;
            r_box_y <= i_box_y;
            r_box_w <= i_box_w;
            r_box_h <= i_box_h;
            r_row   <= i_grid_row;
            r_col   <= i_grid_col;
            r_brk   <= i_can_break;
        end
        r_res_hit    <= n_res_hit;
        r_res_broken <= n_res_broken;
        r_res_row    <= n_res_row;
        r_res_col    <= n_res_col;
        r_res_status <= n_res_status;
    end

    // Output register: loads only when empty or being taken, so a stalled
    // beat holds its payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_slot_free) begin
            r_hit     <= r_res_hit;
            r_broken  <= r_res_broken;
            r_hit_row <= r_res_row;
            r_hit_col <= r_res_col;
            r_status  <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_broken    = r_broken;
    assign o_hit_row   = r_hit_row;
    assign o_hit_col   = r_hit_col;
    assign o_status    = r_status;

endmodule

FILE: sim/tile_collision_table_tb.sv
module tile_collision_table_tb;

    localparam int MAX_TILES   = 256;
    localparam int COORD_BITS  = 16;
    localparam int SIZE_W      = tct_pkg::SIZE_W;
    localparam int GRID_W      = tct_pkg::GRID_W;
    // A query walks the whole cell chain before its result appears.
    localparam int QUERY_LAT   = MAX_TILES + 3;
    // Cycles with no beat moved on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 20 * QUERY_LAT;
    // Slots in the ring of expected results; far more than can be outstanding.
    localparam int EXP_DEPTH   = 16;

    // The one opcode value that the block is meant to ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIZE_W-1:0]     w;
        logic [SIZE_W-1:0]     h;
        logic [GRID_W-1:0]     row;
        logic [GRID_W-1:0]     col;
        logic                  can_break;
    } t_table_op;

    typedef struct packed {
        logic              hit;
        logic              broken;
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
        logic              status;
    } t_table_result;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            opcode;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [SIZE_W-1:0]     box_w;
    logic [SIZE_W-1:0]     box_h;
    logic [GRID_W-1:0]     grid_row;
    logic [GRID_W-1:0]     grid_col;
    logic                  can_break;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic                  broken;
    logic [GRID_W-1:0]     hit_row;
    logic [GRID_W-1:0]     hit_col;
    logic                  status;

    // Shadow copy of the tile table, updated as each beat is accepted.
    int   tile_x   [MAX_TILES];
    int   tile_y   [MAX_TILES];
    int   tile_w   [MAX_TILES];
    int   tile_h   [MAX_TILES];
    logic [GRID_W-1:0] tile_row [MAX_TILES];
    logic [GRID_W-1:0] tile_col [MAX_TILES];
    logic tile_active [MAX_TILES];
    int   tile_count;

    // Expected results in order; the sender fills, the checker drains.
    t_table_result exp_ring [EXP_DEPTH];
    int            n_sent = 0;
    int            n_checked = 0;
    int            failures;
    int            quiet_cycles;

    // Percentages for the idling of the sender and the stalling of the receiver.
    int gap_pct;
    int stall_pct;

    always #4 clk = ~clk;

    tile_collision_table #(
        .MAX_TILES (MAX_TILES),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_opcode   (opcode),
        .i_box_x    (box_x),
        .i_box_y    (box_y),
        .i_box_w    (box_w),
        .i_box_h    (box_h),
        .i_grid_row (grid_row),
        .i_grid_col (grid_col),
        .i_can_break(can_break),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_hit      (hit),
        .o_broken   (broken),
        .o_hit_row  (hit_row),
        .o_hit_col  (hit_col),
        .o_status   (status)
    );

    // Works out the result of one operation on the shadow table and applies its
    // side effects. Coordinates are widened to int before any sum is formed, so
    // the inclusive edge comparisons can never wrap.
    function automatic t_table_result predict_table_op(input t_table_op op);
        t_table_result res;
        int qx, qy, qw, qh;
        int i;
        logic found;
        res   = '0;
        qx    = int'($signed(op.x));
        qy    = int'($signed(op.y));
        qw    = int'(op.w);
        qh    = int'(op.h);
        found = 1'b0;
        case (op.opcode)
            tct_pkg::OP_ADD: begin
                if (tile_count < MAX_TILES) begin
                    tile_x[tile_count]      = qx;
                    tile_y[tile_count]      = qy;
                    tile_w[tile_count]      = qw;
                    tile_h[tile_count]      = qh;
                    tile_row[tile_count]    = op.row;
                    tile_col[tile_count]    = op.col;
                    tile_active[tile_count] = 1'b1;
                    tile_count++;
                end else begin
                    res.status = tct_pkg::STATUS_FULL;
                end
            end
            tct_pkg::OP_CLEAR: begin
                tile_count = 0;
            end
            tct_pkg::OP_QUERY: begin
                i = 0;
                while (!found && i < tile_count) begin
                    if (tile_active[i] &&
                        qx + qw >= tile_x[i] && tile_x[i] + tile_w[i] >= qx &&
                        qy + qh >= tile_y[i] && tile_y[i] + tile_h[i] >= qy) begin
                        found   = 1'b1;
                        res.hit = 1'b1;
                        res.row = tile_row[i];
                        res.col = tile_col[i];
                        if (op.can_break) begin
                            tile_active[i] = 1'b0;
                            res.broken     = 1'b1;
                        end
                    end
                    i++;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_table_op make_op(input logic [1:0] code, input int x, input int y,
                                          input int w, input int h, input int row,
                                          input int col, input logic brk);
        t_table_op op;
        op.opcode    = code;
        op.x         = x[COORD_BITS-1:0];
        op.y         = y[COORD_BITS-1:0];
        op.w         = w[SIZE_W-1:0];
        op.h         = h[SIZE_W-1:0];
        op.row       = row[GRID_W-1:0];
        op.col       = col[GRID_W-1:0];
        op.can_break = brk;
        return op;
    endfunction

    // Tiles mostly fall in a small patch of the plane so that they overlap each
    // other and queries find them; the rest spread over the whole coordinate range.
    function automatic t_table_op random_tile();
        t_table_op op;
        op = make_op(tct_pkg::OP_ADD, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, 1'($urandom_range(1)));
        if ($urandom_range(3) != 0) begin
            op.x = COORD_BITS'(int'($urandom_range(400)) - 200);
            op.y = COORD_BITS'(int'($urandom_range(400)) - 200);
            op.w = SIZE_W'($urandom_range(40));
            op.h = SIZE_W'($urandom_range(40));
        end
        return op;
    endfunction

    // Most queries are aimed at a stored tile, landing anywhere from one step
    // short of its edges to one step beyond, so touches and near misses both occur.
    function automatic t_table_op random_query();
        t_table_op op;
        int idx, qw, qh;
        op = random_tile();
        op.opcode = tct_pkg::OP_QUERY;
        if (tile_count > 0 && $urandom_range(9) < 7) begin
            idx  = int'($urandom_range(tile_count - 1));
            qw   = int'($urandom_range(30));
            qh   = int'($urandom_range(30));
            op.w = SIZE_W'(qw);
            op.h = SIZE_W'(qh);
            op.x = COORD_BITS'(tile_x[idx] - qw - 1 +
                               int'($urandom_range(qw + tile_w[idx] + 2)));
            op.y = COORD_BITS'(tile_y[idx] - qh - 1 +
                               int'($urandom_range(qh + tile_h[idx] + 2)));
        end
        return op;
    endfunction

    // Offers one beat, after an optional idle gap, and holds it until accepted.
    // The expected result is worked out at the edge where the beat is taken.
    task automatic send_op(input t_table_op op);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op.opcode;
        box_x     <= op.x;
        box_y     <= op.y;
        box_w     <= op.w;
        box_h     <= op.h;
        grid_row  <= op.row;
        grid_col  <= op.col;
        can_break <= op.can_break;
        do
            @(posedge clk);
        while (in_stall);
        exp_ring[n_sent[3:0]] = predict_table_op(op);
        n_sent++;
    endtask

    // Holds the sender back until every outstanding result has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (n_sent != n_checked)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            failures++;
        end
    endtask

    // Result checker, receiver stall and watchdog share one clocked process.
    always @(posedge clk) begin
        t_table_result exp_res;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tile_collision_table_tb NOT OK");
                $finish;
            end else if (out_valid && !out_stall) begin
                if (n_sent == n_checked) begin
                    $error("result beat arrived with no operation outstanding");
                    failures++;
                end else begin
                    exp_res = exp_ring[n_checked[3:0]];
                    n_checked <= n_checked + 1;
                    check_field("hit", 32'(exp_res.hit), 32'(hit));
                    check_field("broken", 32'(exp_res.broken), 32'(broken));
                    check_field("hit_row", 32'(exp_res.row), 32'(hit_row));
                    check_field("hit_col", 32'(exp_res.col), 32'(hit_col));
                    check_field("status", 32'(exp_res.status), 32'(status));
                end
            end
        end
    end

    // Edge cases on a nearly empty table: zero-sized boxes, the corners of the
    // coordinate range, touching edges, misses by a single step, breaking two
    // stacked tiles in turn, the unused opcode and a clear.
    task automatic test_directed();
        send_op(make_op(tct_pkg::OP_QUERY, 0, 0, 32767, 32767, 0, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_ADD, -32768, -32768, 0, 0, 0, 0, 1'b0));
        send_op(make_op(tct_pkg::OP_ADD, 32767, 32767, 32767, 32767, 1023, 1023, 1'b0));
        send_op(make_op(tct_pkg::OP_ADD, 100, 100, 10, 10, 5, 9, 1'b0));
        send_op(make_op(tct_pkg::OP_ADD, 100, 100, 10, 10, 6, 10, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, -32768, -32768, 0, 0, 0, 0, 1'b0));
        send_op(make_op(tct_pkg::OP_QUERY, 110, 110, 0, 0, 0, 0, 1'b0));
        send_op(make_op(tct_pkg::OP_QUERY, 111, 100, 5, 5, 0, 0, 1'b0));
        send_op(make_op(tct_pkg::OP_QUERY, 100, 89, 10, 10, 0, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, 90, 90, 10, 10, 1023, 1023, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, 90, 90, 10, 10, 0, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, 90, 90, 10, 10, 0, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, 32767, 32767, 32767, 32767, 0, 0, 1'b0));
        send_op(make_op(tct_pkg::OP_QUERY, -32768, -32768, 32767, 32767, 0, 0, 1'b0));
        send_op(make_op(OP_UNUSED, -1, -1, 32767, 32767, 1023, 1023, 1'b1));
        send_op(make_op(tct_pkg::OP_CLEAR, -1, -1, 32767, 32767, 1023, 1023, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, -32768, -32768, 32767, 32767, 0, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, 0, 0, 32767, 32767, 0, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_ADD, 0, 0, 0, 0, 1023, 0, 1'b1));
        send_op(make_op(tct_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1023, 1'b0));
    endtask

    // Fills the table to capacity, pushes further adds that must be dropped,
    // queries the full table, then checks that a clear makes room again.
    task automatic test_full_table();
        int k;
        send_op(make_op(tct_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
        for (k = 0; k < MAX_TILES + 3; k++)
            send_op(random_tile());
        for (k = 0; k < 6; k++)
            send_op(random_query());
        send_op(make_op(tct_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
        send_op(random_tile());
        send_op(random_query());
    endtask

    // Random traffic shaped like real use: adds and queries dominate, with the
    // odd clear and the odd beat carrying the unused opcode.
    task automatic test_random_mix(input int n_items);
        int k, pick;
        t_table_op op;
        for (k = 0; k < n_items; k++) begin
            pick = int'($urandom_range(99));
            if (pick < 4) begin
                op = random_tile();
                op.opcode = tct_pkg::OP_CLEAR;
            end else if (pick < 7) begin
                op = random_tile();
                op.opcode = OP_UNUSED;
            end else if (pick < 52) begin
                op = random_tile();
            end else begin
                op = random_query();
            end
            send_op(op);
        end
    endtask

    initial begin
        failures   = 0;
        tile_count = 0;
        gap_pct    = 0;
        stall_pct  = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= tct_pkg::OP_ADD;
        box_x     <= '0;
        box_y     <= '0;
        box_w     <= '0;
        box_h     <= '0;
        grid_row  <= '0;
        grid_col  <= '0;
        can_break <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 22;
        stall_pct = 22;
        test_directed();
        wait_for_results();

        gap_pct   = 0;
        stall_pct = 83;
        test_full_table();
        wait_for_results();

        gap_pct   = 0;
        stall_pct = 0;
        test_random_mix(390);
        wait_for_results();
        gap_pct   = 83;
        stall_pct = 0;
        test_random_mix(390);
        wait_for_results();
        gap_pct   = 0;
        stall_pct = 83;
        test_random_mix(390);
        wait_for_results();
        gap_pct   = 22;
        stall_pct = 22;
        test_random_mix(390);

        // Let any stray result surface before the verdict.
        wait_for_results();
        repeat (QUERY_LAT + 8) @(posedge clk);
        if (failures == 0)
            $display("tile_collision_table_tb OK");
        else
            $display("tile_collision_table_tb NOT OK");
        $finish;
    end

endmodule
